// ===== hw/rtl/first_seen_index_interning_assert.svh =====
// Assertion macros for the first-seen index interning block.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef FIRST_SEEN_INDEX_INTERNING_ASSERT_SVH
`define FIRST_SEEN_INDEX_INTERNING_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fsi_pkg.sv =====
// Shared types and constants for the first-seen index interning block.
// No dependencies.
`default_nettype none

package fsi_pkg;

  localparam int GIDX_W = 16;
  localparam int LIDX_W = 4;
  localparam int TVAL_W = 16;

  localparam logic FUNC_INTERN = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef struct packed {
    logic              func;
    logic [GIDX_W-1:0] global_index;
  } in_word_t;

  typedef struct packed {
    logic [LIDX_W-1:0] local_index;
    logic              was_new;
    logic              overflow;
    logic [TVAL_W-1:0] table_value;
    logic              is_table_entry;
    logic              table_empty;
    logic              last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DUMP
  } fsi_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted input word
    logic lookup;      // match, append if new, load the intern result
    logic dump_load;   // load the entry at the dump pointer, advance it
    logic emit_empty;  // load the empty-table result
    logic clear;       // empty the table and rewind the dump pointer
  } fsi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_finish;   // latched word asks for a finish
    logic count_zero;  // table holds no entries
    logic at_last;     // dump pointer sits on the final entry
    logic out_free;    // output register can take a word this cycle
  } fsi_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fsi_ctrl.sv =====
// Controller state machine for the interning block.
// Depends on fsi_pkg.
`default_nettype none

module fsi_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire fsi_pkg::fsi_sts_t sts,
  output fsi_pkg::fsi_cmd_t     cmd
);

  fsi_pkg::fsi_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      fsi_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = fsi_pkg::ST_EXEC;
        end
      end
      fsi_pkg::ST_EXEC: begin
        if (sts.is_finish) begin
          if (!sts.count_zero) begin
            state_nxt = fsi_pkg::ST_DUMP;
          end else if (sts.out_free) begin
            cmd.emit_empty = 1'b1;
            cmd.clear      = 1'b1;
            state_nxt      = fsi_pkg::ST_IDLE;
          end
        end else if (sts.out_free) begin
          cmd.lookup = 1'b1;
          state_nxt  = fsi_pkg::ST_IDLE;
        end
      end
      fsi_pkg::ST_DUMP: begin
        if (sts.out_free) begin
          cmd.dump_load = 1'b1;
          if (sts.at_last) begin
            cmd.clear = 1'b1;
            state_nxt = fsi_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = fsi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fsi_datapath.sv =====
// Datapath: value table with parallel match, entry count, dump pointer,
// input latch and output register. Depends on fsi_pkg.
`default_nettype none

module fsi_datapath #(
  parameter int TABLE_DEPTH = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fsi_pkg::in_word_t in_word,
  input  wire fsi_pkg::fsi_cmd_t cmd,
  output fsi_pkg::fsi_sts_t      sts,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output fsi_pkg::out_word_t     out_word
);

  // Only the low bits of the 16-bit field take part in matching.
  localparam int SW = (VALUE_WIDTH < fsi_pkg::GIDX_W) ? VALUE_WIDTH : fsi_pkg::GIDX_W;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [SW-1:0] slot_r [TABLE_DEPTH];
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic                   func_r;
  logic [SW-1:0]          key_r;
  logic                   out_valid_r, out_valid_nxt;
  fsi_pkg::out_word_t     out_word_r, out_word_nxt;

  logic          hit;
  logic [IW-1:0] hit_idx;
  logic          full;
  logic          append;

  // Parallel compare against every live entry. Live entries are distinct,
  // so at most one matches and an OR of the indices encodes it.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if ((CW'(i) < count_r) && (slot_r[i] == key_r)) begin
        hit     = 1'b1;
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign full   = (count_r == CW'(TABLE_DEPTH));
  assign append = cmd.lookup && !hit && !full;

  assign sts.is_finish  = (func_r == fsi_pkg::FUNC_FINISH);
  assign sts.count_zero = (count_r == '0);
  assign sts.at_last    = ((CW'(ptr_r) + CW'(1)) == count_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    if (append) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.dump_load) begin
      ptr_nxt = ptr_r + IW'(1);
    end
    if (cmd.clear) begin
      count_nxt = '0;
      ptr_nxt   = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    if (cmd.lookup) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      out_word_nxt.last = 1'b1;
      if (hit) begin
        out_word_nxt.local_index = fsi_pkg::LIDX_W'(hit_idx);
      end else if (!full) begin
        out_word_nxt.local_index = fsi_pkg::LIDX_W'(count_r);
        out_word_nxt.was_new     = 1'b1;
      end else begin
        out_word_nxt.overflow = 1'b1;
      end
    end else if (cmd.dump_load) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      out_word_nxt.local_index    = fsi_pkg::LIDX_W'(ptr_r);
      out_word_nxt.table_value    = fsi_pkg::TVAL_W'(slot_r[ptr_r]);
      out_word_nxt.is_table_entry = 1'b1;
      out_word_nxt.last           = sts.at_last;
    end else if (cmd.emit_empty) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      out_word_nxt.table_empty = 1'b1;
      out_word_nxt.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (cmd.capture) begin
      func_r <= in_word.func;
      key_r  <= in_word.global_index[SW-1:0];
    end
    if (append) begin
      slot_r[count_r[IW-1:0]] <= key_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ===== hw/rtl/first_seen_index_interning.sv =====
// Channel  Direction  Word type            Handshake
// in_      input      fsi_pkg::in_word_t   in_valid / in_stall
// out_     output     fsi_pkg::out_word_t  out_valid / out_stall
//
// Steps: an intern word is latched, then matched and appended; a finish is latched,
// then dumps its N stored entries, or emits one empty-table result when the table
// is empty. The controller sequences one word at a time, and the dump reads one table
// entry per cycle through the single dump pointer while the output register is free.
// Reset: synchronous on rst_n low; clears the entry count, dump pointer,
// controller state and output valid. Stored values keep whatever they hold.
// Stalls: out_stall holds the output register; the controller waits in
// place until the register frees up, and in_stall stays high meanwhile.
// Depends on fsi_pkg, fsi_ctrl, fsi_datapath and the assertion header.
`default_nettype none

`include "first_seen_index_interning_assert.svh"

module first_seen_index_interning #(
  parameter int TABLE_DEPTH = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fsi_pkg::in_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fsi_pkg::out_word_t     out_word
);

  // Command and status between the controller and the datapath.
  fsi_pkg::fsi_cmd_t cmd;
  fsi_pkg::fsi_sts_t sts;

  // Controller: accept one word in idle, then sequence its lookup, dump or empty-table result.
  fsi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: hold the table, count and output register.
  fsi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // An accepted word keeps the input closed for the next cycle.
  `FSI_ASSERT_NXT(a_accept_closes, in_valid && !in_stall, in_stall, "input reopened after accept")
  // Never load the output register while a held word still waits.
  `FSI_ASSERT_IMP(a_no_overwrite, cmd.lookup || cmd.dump_load || cmd.emit_empty, sts.out_free, "output overwritten")
  // An intern result is always the single, final result of its word.
  `FSI_ASSERT_IMP(a_intern_last, out_valid && !out_word.is_table_entry, out_word.last, "intern result without last")
  // A word is never both appended and an overflow.
  `FSI_ASSERT_IMP(a_new_xor_ovf, out_valid, !(out_word.was_new && out_word.overflow), "new and overflow together")

endmodule

`default_nettype wire
